// ----- rtl/tpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tpsm_pkg
// Shared widths, constants and types of the triac pulse-skip modulator.
// ----------------------------------------------------------------------------
package tpsm_pkg;

	// mains phase timer range and modulation period limit
	localparam int unsigned PHASE_MAX  = 256;
	localparam int unsigned PERIOD_CAP = 1024;

	// field and state widths
	localparam int unsigned PHASE_W  = 9;
	localparam int unsigned CYCLE_W  = 11;
	localparam int unsigned HALF_W   = 12;
	localparam int unsigned FIRED_W  = 11;
	localparam int unsigned IDX_W    = 2;
	localparam int unsigned S_DATA_W = 16;
	localparam int unsigned M_DATA_W = 8;

	// shift-add multiplier: 12-bit multiplicand, 11-bit multiplier
	localparam int unsigned MUL_A_W   = 12;
	localparam int unsigned MUL_B_W   = 11;
	localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
	localparam int unsigned MUL_STEPS = MUL_B_W;
	localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS + 1);

	localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_W'(PHASE_MAX / 2);
	localparam logic [CYCLE_W-1:0] CYCLE_MIN  = CYCLE_W'(2);
	localparam logic [CYCLE_W-1:0] CYCLE_LIM  = CYCLE_W'(PERIOD_CAP);
	localparam logic [CYCLE_W-1:0] CYCLE_RST  = CYCLE_W'(2);

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_CYCLE_COUNT   = 2'd0,
		REG_BRIGHTNESS    = 2'd1,
		REG_GATE_INVERTED = 2'd2
	} reg_index_t;

	// multiplier status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

// ----- rtl/tpsm_mul.sv -----
// ----------------------------------------------------------------------------
// tpsm_mul
// Iterative shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tpsm_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tpsm_pkg::MUL_A_W-1:0]   op_a,
	input  logic [tpsm_pkg::MUL_B_W-1:0]   op_b,
	output tpsm_pkg::mul_stat_t            stat,
	output logic [tpsm_pkg::PROD_W-1:0]    product
);
	import tpsm_pkg::*;

	logic [PROD_W-1:0]    mcand_q;
	logic [MUL_B_W-1:0]   mplier_q;
	logic [PROD_W-1:0]    acc_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// control: step counter, busy and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == MUL_CNT_W'(1));
			if (start) begin
				cnt_q  <= MUL_CNT_W'(MUL_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: add shifted multiplicand when the low multiplier bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= PROD_W'(op_a);
			mplier_q <= op_b;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("multiplier done while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("multiplier did not go busy after start");

endmodule

// ----- rtl/triac_pulse_skip_modulator_unit.sv -----
// ----------------------------------------------------------------------------
// triac_pulse_skip_modulator_unit
// Pulse-skip modulation of a triac dimmer: counts mains half-cycles from
// phase timer ticks and decides once per full cycle whether the gate fires.
// ----------------------------------------------------------------------------
// Flow: a tick that gives no result is handled in ST_IDLE alone; a decision
// without arithmetic goes from ST_IDLE through ST_EMIT into the output
// register, a full decision first runs two 11-step shift-add passes in
// ST_MUL_A and ST_MUL_B. Throughput: one tick per cycle when no decision is
// due, else input is held off until ST_EMIT is left, which waits for a free
// output register. Reset clears counters, cycle_count to 2, others to 0.
module triac_pulse_skip_modulator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            wr_en,
	input  logic [tpsm_pkg::IDX_W-1:0]      wr_index,
	input  logic [tpsm_pkg::CYCLE_W-1:0]    wr_data,
	// tick stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [tpsm_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [8:0] phase_position
	// decision stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [tpsm_pkg::M_DATA_W-1:0]   m_axis_tdata   // [0] gate_level, [1] fire_decision
);
	import tpsm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [CYCLE_W-1:0]  cycle_count_q;
	logic [CYCLE_W-1:0]  brightness_q;
	logic                gate_inverted_q;
	logic [HALF_W-1:0]   half_cycle_count_q;
	logic [FIRED_W-1:0]  fired_count_q;
	logic                half_done_q;
	logic [CYCLE_W-1:0]  n_q;
	logic [PROD_W-1:0]   prod_q;
	logic                fire_q;
	logic                m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;

	logic                accept;
	logic [PHASE_W-1:0]  phase;
	logic                phase_high;
	logic [HALF_W-1:0]   half_inc;
	logic [CYCLE_W-1:0]  n_inc;
	logic                n_over;
	logic                need_mul;
	logic                emit_free;
	logic                mul_start;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	mul_stat_t           mul_stat;
	logic [PROD_W-1:0]   mul_prod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count_q   <= CYCLE_RST;
			brightness_q    <= '0;
			gate_inverted_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_CYCLE_COUNT: begin
					if (wr_data >= CYCLE_MIN && wr_data <= CYCLE_LIM) begin
						cycle_count_q <= wr_data;
						brightness_q  <= '0;
					end
				end
				REG_BRIGHTNESS: begin
					if (wr_data <= cycle_count_q) begin
						brightness_q <= wr_data;
					end
				end
				REG_GATE_INVERTED: gate_inverted_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// tick decode
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign phase         = s_axis_tdata[PHASE_W-1:0];
	assign phase_high    = phase > PHASE_HALF;
	assign half_inc      = half_cycle_count_q + 1'b1;
	assign n_inc         = half_inc[HALF_W-1:1];
	assign n_over        = n_inc > cycle_count_q;
	assign need_mul      = accept && !phase_high && !half_done_q && !half_inc[0]
		&& !n_over && (n_inc != '0);
	assign emit_free     = !m_valid_q || m_axis_tready;

	// shared multiplier operands: cycle_count*fired_count, then (brightness+1)*n
	always_comb begin
		mul_start = need_mul || (state_q == ST_MUL_A && mul_stat.done);
		if (state_q == ST_MUL_A) begin
			mul_a = MUL_A_W'(brightness_q) + 1'b1;
			mul_b = n_q;
		end else begin
			mul_a = MUL_A_W'(cycle_count_q);
			mul_b = fired_count_q;
		end
	end

	tpsm_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.stat    (mul_stat),
		.product (mul_prod)
	);

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			half_cycle_count_q <= '0;
			fired_count_q      <= '0;
			half_done_q        <= 1'b0;
			n_q                <= '0;
			prod_q             <= '0;
			fire_q             <= 1'b0;
			m_valid_q          <= 1'b0;
			m_data_q           <= '0;
		end else begin
			// output item loads on emit, clears once taken
			if (state_q == ST_EMIT && emit_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (phase_high) begin
							half_done_q <= 1'b0;
						end else if (!half_done_q) begin
							half_done_q <= 1'b1;
							if (half_inc[0]) begin
								half_cycle_count_q <= half_inc;
							end else if (n_over) begin
								// period over: both counters restart
								half_cycle_count_q <= '0;
								fired_count_q      <= '0;
								fire_q             <= (brightness_q != '0);
								state_q            <= ST_EMIT;
							end else if (n_inc == '0) begin
								half_cycle_count_q <= half_inc;
								fire_q             <= (brightness_q != '0);
								state_q            <= ST_EMIT;
							end else begin
								half_cycle_count_q <= half_inc;
								n_q                <= n_inc;
								state_q            <= ST_MUL_A;
							end
						end
					end
				end
				ST_MUL_A: begin
					if (mul_stat.done) begin
						prod_q  <= mul_prod;
						state_q <= ST_MUL_B;
					end
				end
				ST_MUL_B: begin
					// t = prod/n; fire when 1 <= t <= brightness
					if (mul_stat.done) begin
						fire_q  <= (prod_q >= PROD_W'(n_q)) && (prod_q < mul_prod);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_free) begin
						m_data_q  <= {{(M_DATA_W - 2){1'b0}}, fire_q,
							fire_q ^ gate_inverted_q};
						if (fire_q) begin
							fired_count_q <= fired_count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_mul_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_MUL_A || state_q == ST_MUL_B))
		else $error("multiplier finished outside a multiply state");

	a_mul_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_EMIT) |-> !mul_stat.busy)
		else $error("multiplier busy outside a multiply state");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && emit_free) |=> (m_valid_q && state_q == ST_IDLE))
		else $error("decision not loaded into output register");

	a_even_decision: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (!half_cycle_count_q[0] && half_done_q))
		else $error("decision made on an odd half-cycle");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_high) |=> !half_done_q)
		else $error("detector not re-armed by a high phase tick");

endmodule
